@@ hdl/mi4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg
// shared widths, defaults and cofactor addressing for the 4x4 inverse
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int ENTRY_W       = 32;
  localparam int POS_W         = 4;
  localparam int DEPTH         = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_W         = 98;
  localparam int COF_W         = 96;
  localparam int DET_W         = 130;
  localparam int DMAG_W        = 129;
  localparam int REM_W         = 130;
  localparam int Q_W           = 33;

  // column order of the six 3x3 minor terms, even ones first
  function automatic logic [1:0] perm3(input logic [2:0] p, input logic [1:0] f);
    logic [5:0] row;
    begin
      case (p)
        3'd0:    row = {2'd2, 2'd1, 2'd0};
        3'd1:    row = {2'd0, 2'd2, 2'd1};
        3'd2:    row = {2'd1, 2'd0, 2'd2};
        3'd3:    row = {2'd1, 2'd2, 2'd0};
        3'd4:    row = {2'd0, 2'd1, 2'd2};
        3'd5:    row = {2'd2, 2'd0, 2'd1};
        default: row = 6'd0;
      endcase
      perm3 = row[2*f +: 2];
    end
  endfunction

  // store address of factor f of term p of the minor that drops (row, col)
  function automatic logic [3:0] entry_addr(input logic [1:0] row, input logic [1:0] col,
                                            input logic [2:0] p, input logic [1:0] f);
    logic [1:0] r;
    logic [1:0] ci;
    logic [1:0] c;
    begin
      r  = (f < row) ? f : f + 2'd1;
      ci = perm3(p, f);
      c  = (ci < col) ? ci : ci + 2'd1;
      entry_addr = {c, r};
    end
  endfunction

endpackage

@@ hdl/mi4_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4 channel interfaces
// matrix entry request channel and inverse result channel
// ----------------------------------------------------------------------------
interface entry_if import mi4_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ENTRY_W-1:0] entry_value;

  modport source (output valid, output entry_value, input ready);
  modport sink   (input valid, input entry_value, output ready);
endinterface

interface result_if import mi4_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ENTRY_W-1:0] inverse_value;
  logic        [POS_W-1:0]   position;
  logic                      singular;
  logic                      last_entry;

  modport source (output valid, output inverse_value, output position,
                  output singular, output last_entry, input ready);
  modport sink   (input valid, input inverse_value, input position,
                  input singular, input last_entry, output ready);
endinterface

@@ hdl/mi4_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/matrix4_inverse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_inverse
// 4x4 fixed point inverse by the adjugate, entries in and out column-major
//
// channel   dir  payload
// entries   in   entry_value
// results   out  inverse_value, position, singular, last_entry
//
// entries are taken one per cycle; after the sixteenth the block works alone:
// it first forms the determinant, then for each result it sums the six triple
// products of its cofactor through the one 32x32 multiplier and divides the
// cofactor by the determinant in the bit-serial divider, with saturation.
// after the determinant a singular matrix gives its 16 results one per cycle
// while ready; a stalled result only holds the sequencer at its next result.
// rst is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module matrix4_inverse import mi4_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  entry_if.sink   entries,
  result_if.source results
);

  localparam int NUM_W = COF_W + 2 * FRAC_BITS;
  localparam int CMP_W = (NUM_W > DMAG_W + 32) ? NUM_W : DMAG_W + 32;

  typedef enum logic [3:0] {
    S_LOAD, S_TERM, S_CEND, S_DMUL, S_DETEND, S_DSETUP, S_DIV, S_ROUND, S_FIN
  } state_t;

  state_t             state;
  logic [3:0]         load_count;
  logic               det_mode;
  logic [1:0]         cof_row;
  logic [1:0]         cof_col;
  logic [2:0]         p;
  logic [2:0]         ph;
  logic [3:0]         k;
  logic [4:0]         cnt;
  logic [31:0]        ma;
  logic [31:0]        mc;
  logic [63:0]        pab;
  logic [63:0]        mprod;
  logic               tneg;
  logic [ACC_W-1:0]   acc;
  logic [COF_W-1:0]   cmag;
  logic               cneg;
  logic [DET_W-1:0]   det;
  logic [DMAG_W-1:0]  dmag;
  logic               dneg;
  logic               sing;
  logic [REM_W-1:0]   rem;
  logic [31:0]        low;
  logic [Q_W-1:0]     q;
  logic               over;
  logic [31:0]        val;

  logic               out_valid;
  logic [31:0]        out_value;
  logic [3:0]         out_pos;
  logic               out_sing;
  logic               out_last;

  logic [3:0]         raddr;
  logic [31:0]        rdata;
  logic [31:0]        rabs;
  logic [31:0]        mul_x;
  logic [31:0]        mul_y;
  logic [95:0]        acc_sh;
  logic [ACC_W-1:0]   acc_add;
  logic [127:0]       det_sh;
  logic [DET_W-1:0]   det_add;
  logic [ACC_W-1:0]   acc_mag;
  logic [DET_W-1:0]   det_mag;
  logic [NUM_W-1:0]   num;
  logic               over_c;
  logic [REM_W-1:0]   r2;
  logic               ge;
  logic               rnd;
  logic [Q_W-1:0]     qr;
  logic               rneg;
  logic [Q_W-1:0]     lim;
  logic [Q_W-1:0]     qmag;
  logic [3:0]         k_next;
  logic               ram_we;

  mi4_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_count),
    .wdata (entries.entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign entries.ready = (state == S_LOAD);
  assign ram_we        = entries.valid && entries.ready;

  assign results.valid         = out_valid;
  assign results.inverse_value = out_value;
  assign results.position      = out_pos;
  assign results.singular      = out_sing;
  assign results.last_entry    = out_last;

  assign rabs = rdata[31] ? (~rdata + 32'd1) : rdata;

  always_comb begin
    raddr = 4'd0;
    if (state == S_TERM) begin
      case (ph)
        3'd0:    raddr = entry_addr(cof_row, cof_col, p, 2'd0);
        3'd1:    raddr = entry_addr(cof_row, cof_col, p, 2'd1);
        3'd2:    raddr = entry_addr(cof_row, cof_col, p, 2'd2);
        default: raddr = 4'd0;
      endcase
    end else if (state == S_CEND) begin
      raddr = {cof_col, 2'b00};
    end
  end

  always_comb begin
    mul_x = 32'd0;
    mul_y = 32'd0;
    if (state == S_TERM) begin
      case (ph)
        3'd2:    begin mul_x = ma;          mul_y = rabs; end
        3'd4:    begin mul_x = pab[31:0];   mul_y = mc;   end
        3'd5:    begin mul_x = pab[63:32];  mul_y = mc;   end
        default: begin mul_x = 32'd0;       mul_y = 32'd0; end
      endcase
    end else if (state == S_DMUL) begin
      case (ph)
        3'd1:    begin mul_x = cmag[31:0];  mul_y = mc;   end
        3'd2:    begin mul_x = cmag[63:32]; mul_y = mc;   end
        3'd3:    begin mul_x = cmag[95:64]; mul_y = mc;   end
        default: begin mul_x = 32'd0;       mul_y = 32'd0; end
      endcase
    end
  end

  always_comb begin
    acc_sh  = (ph == 3'd6) ? {mprod, 32'd0} : {32'd0, mprod};
    acc_add = tneg ? (~ACC_W'(acc_sh) + ACC_W'(1)) : ACC_W'(acc_sh);
    case (ph)
      3'd3:    det_sh = {32'd0, mprod, 32'd0};
      3'd4:    det_sh = {mprod, 64'd0};
      default: det_sh = {64'd0, mprod};
    endcase
    det_add = tneg ? (~DET_W'(det_sh) + DET_W'(1)) : DET_W'(det_sh);
    acc_mag = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
    det_mag = det[DET_W-1] ? (~det + DET_W'(1)) : det;
  end

  always_comb begin
    num    = NUM_W'(cmag) << (2 * FRAC_BITS);
    over_c = CMP_W'(num) >= CMP_W'({dmag, 32'd0});
    r2     = {rem[REM_W-2:0], low[31]};
    ge     = r2 >= REM_W'(dmag);
    rnd    = {rem[REM_W-2:0], 1'b0} >= REM_W'(dmag);
    qr     = q + Q_W'(rnd);
    rneg   = cneg ^ dneg;
    lim    = rneg ? Q_W'(33'h080000000) : Q_W'(33'h07FFFFFFF);
    qmag   = (over || (qr > lim)) ? lim : qr;
    k_next = k + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= 4'd0;
      out_valid  <= 1'b0;
      det_mode   <= 1'b0;
      p          <= 3'd0;
      ph         <= 3'd0;
      k          <= 4'd0;
      cnt        <= 5'd0;
      sing       <= 1'b0;
    end else begin
      mprod <= mul_x * mul_y;
      if (out_valid && results.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (ram_we) begin
            if (load_count == 4'd15) begin
              load_count <= 4'd0;
              state      <= S_TERM;
              det_mode   <= 1'b1;
              cof_row    <= 2'd0;
              cof_col    <= 2'd0;
              p          <= 3'd0;
              ph         <= 3'd0;
              acc        <= '0;
              det        <= '0;
            end else begin
              load_count <= load_count + 4'd1;
            end
          end
        end
        S_TERM: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd1: begin
              ma   <= rabs;
              tneg <= rdata[31];
            end
            3'd2: tneg <= tneg ^ rdata[31];
            3'd3: begin
              pab  <= mprod;
              mc   <= rabs;
              tneg <= tneg ^ rdata[31] ^ (p >= 3'd3);
            end
            3'd5: acc <= acc + acc_add;
            3'd6: begin
              acc <= acc + acc_add;
              ph  <= 3'd0;
              if (p == 3'd5) begin
                p     <= 3'd0;
                state <= S_CEND;
              end else begin
                p <= p + 3'd1;
              end
            end
            default: ;
          endcase
        end
        S_CEND: begin
          cmag  <= acc_mag[COF_W-1:0];
          cneg  <= acc[ACC_W-1] ^ cof_row[0] ^ cof_col[0];
          ph    <= 3'd0;
          state <= det_mode ? S_DMUL : S_DSETUP;
        end
        S_DMUL: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd0: begin
              mc   <= rabs;
              tneg <= cneg ^ rdata[31];
            end
            3'd2: det <= det + det_add;
            3'd3: det <= det + det_add;
            3'd4: begin
              det <= det + det_add;
              ph  <= 3'd0;
              if (cof_col == 2'd3) begin
                state <= S_DETEND;
              end else begin
                cof_col <= cof_col + 2'd1;
                acc     <= '0;
                p       <= 3'd0;
                state   <= S_TERM;
              end
            end
            default: ;
          endcase
        end
        S_DETEND: begin
          dmag     <= det_mag[DMAG_W-1:0];
          dneg     <= det[DET_W-1];
          sing     <= (det == '0);
          det_mode <= 1'b0;
          k        <= 4'd0;
          cof_row  <= 2'd0;
          cof_col  <= 2'd0;
          acc      <= '0;
          p        <= 3'd0;
          ph       <= 3'd0;
          state    <= (det == '0) ? S_FIN : S_TERM;
        end
        S_DSETUP: begin
          rem   <= REM_W'(num >> 32);
          low   <= num[31:0];
          q     <= '0;
          cnt   <= 5'd0;
          over  <= over_c;
          state <= over_c ? S_ROUND : S_DIV;
        end
        S_DIV: begin
          rem <= ge ? (r2 - REM_W'(dmag)) : r2;
          q   <= {q[Q_W-2:0], ge};
          low <= {low[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          val   <= rneg ? (~qmag[31:0] + 32'd1) : qmag[31:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_value <= sing ? 32'd0 : val;
            out_pos   <= k;
            out_sing  <= sing;
            out_last  <= (k == 4'd15);
            if (k == 4'd15) begin
              state <= S_LOAD;
            end else begin
              k <= k_next;
              if (!sing) begin
                cof_row <= k_next[3:2];
                cof_col <= k_next[1:0];
                acc     <= '0;
                p       <= 3'd0;
                ph      <= 3'd0;
                state   <= S_TERM;
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the finish step");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sing |-> out_value == 32'd0)
    else $error("singular result carries a nonzero value");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_pos == 4'd15)
    else $error("last result not at position fifteen");

  a_div_nonsing: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> !sing && dmag != '0)
    else $error("divider running on a zero determinant");

endmodule
